/* rtl/gdi_pkg.sv */
// Shared types, constants and calendar tables for the Gregorian date info block.
package gdi_pkg;

  // Field widths of a request and a result.
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned DOY_W   = 9;

  // Calendar limits and month numbers.
  localparam logic [YEAR_W-1:0]  YEAR_MIN = YEAR_W'(1);
  localparam logic [YEAR_W-1:0]  YEAR_MAX = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST = DAY_W'(1);

  // Weekday codes, Monday based.
  localparam logic [WD_W-1:0] WD_SAT = WD_W'(5);
  localparam logic [WD_W-1:0] WD_SUN = WD_W'(6);

  // Year lengths.
  localparam logic [DOY_W-1:0] YEAR_DAYS      = DOY_W'(365);
  localparam logic [DOY_W-1:0] LEAP_YEAR_DAYS = DOY_W'(366);

  // One request: a date.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } req_t;

  // One result.
  typedef struct packed {
    logic               valid_res;
    logic [WD_W-1:0]    weekday;
    logic               is_weekend;
    logic [WD_W-1:0]    days_to_week_end;
    logic [DAY_W-1:0]   days_to_month_end;
    logic [DOY_W-1:0]   days_to_year_end;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
  } rsp_t;

  // Calendar facts of one date, passed from the calendar unit to the top level.
  typedef struct packed {
    logic               date_ok;
    logic [DAY_W-1:0]   days_to_month_end;
    logic [DOY_W-1:0]   days_to_year_end;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;
  } cal_t;

  // Length of a month; zero for a month number outside January to December.
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
      4'd2:    n = leap ? DAY_W'(29) : DAY_W'(28);
      default: n = '0;
    endcase
    return n;
  endfunction

  // Days in a common year before the first of a month.
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] n;
    case (m)
      4'd1:    n = DOY_W'(0);
      4'd2:    n = DOY_W'(31);
      4'd3:    n = DOY_W'(59);
      4'd4:    n = DOY_W'(90);
      4'd5:    n = DOY_W'(120);
      4'd6:    n = DOY_W'(151);
      4'd7:    n = DOY_W'(181);
      4'd8:    n = DOY_W'(212);
      4'd9:    n = DOY_W'(243);
      4'd10:   n = DOY_W'(273);
      4'd11:   n = DOY_W'(304);
      4'd12:   n = DOY_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

  // Month term of the weekday congruence: (31 * mm) / 12 for the March-based month.
  function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] mm);
    logic [DAY_W-1:0] n;
    case (mm)
      4'd1:    n = DAY_W'(2);
      4'd2:    n = DAY_W'(5);
      4'd3:    n = DAY_W'(7);
      4'd4:    n = DAY_W'(10);
      4'd5:    n = DAY_W'(12);
      4'd6:    n = DAY_W'(15);
      4'd7:    n = DAY_W'(18);
      4'd8:    n = DAY_W'(20);
      4'd9:    n = DAY_W'(23);
      4'd10:   n = DAY_W'(25);
      4'd11:   n = DAY_W'(28);
      4'd12:   n = DAY_W'(31);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/gregorian_date_info.sv */
// Top level of the Gregorian date info block: request register, date logic, result register.
//
// Usage: a request carries one Gregorian date (day, month, year) on req with
// req_valid/req_ready. Each request gives exactly one result on rsp with
// rsp_valid/rsp_ready: the Monday-based weekday, a weekend flag, the days left
// to Sunday, to the month end and to the year end (both counting today), and
// the date of the following day. A date that is not real (month outside 1..12,
// day zero or past the month end, year zero or above 9999) clears valid_res
// and gives zero in every other field. The block keeps no state between dates.
// The request is registered at acceptance, the date logic works on the held
// request, and its result is registered into the result register, where it waits
// for rsp_ready. One request per cycle is taken while rsp_ready stays high; the
// request register and the result register form a two-entry pipeline, so a new
// request is taken while a finished result waits. When the receiver holds
// rsp_ready low both entries fill and req_ready falls; nothing is dropped. A
// synchronous reset on rst empties both entries; no result is pending after reset.
module gregorian_date_info
  import gdi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic     hold_valid;
  req_t     hold;
  logic     advance;
  logic [WD_W-1:0] wd;
  cal_t     cal;
  rsp_t     result;

  // The held request moves on whenever the result register is free or being taken.
  assign advance   = !rsp_valid || rsp_ready;
  assign req_ready = !hold_valid || advance;

  gdi_weekday u_weekday (
    .day     (hold.day),
    .month   (hold.month),
    .year    (hold.year),
    .weekday (wd)
  );

  gdi_calendar u_calendar (
    .day   (hold.day),
    .month (hold.month),
    .year  (hold.year),
    .cal   (cal)
  );

  // Assemble the result; an invalid date gives all zeros.
  always_comb begin
    result = '0;
    if (cal.date_ok) begin
      result.valid_res         = 1'b1;
      result.weekday           = wd;
      result.is_weekend        = (wd == WD_SAT) || (wd == WD_SUN);
      result.days_to_week_end  = WD_SUN - wd;
      result.days_to_month_end = cal.days_to_month_end;
      result.days_to_year_end  = cal.days_to_year_end;
      result.next_day          = cal.next_day;
      result.next_month        = cal.next_month;
      result.next_year         = cal.next_year;
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_ready) begin
        hold_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= hold_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
    if (advance && hold_valid) begin
      rsp <= result;
    end
  end

endmodule

/* rtl/gdi_weekday.sv */
// Monday-based day of week of a Gregorian date.
module gdi_weekday
  import gdi_pkg::*;
(
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic [WD_W-1:0]    weekday
);

  localparam int unsigned YY_W  = YEAR_W + 1;
  localparam int unsigned SUM_W = 15;
  // Reciprocal of 100 scaled by 2^19; exact for the year range in use.
  localparam int unsigned R100_SH = 19;
  localparam logic [12:0] R100    = 13'd5243;
  localparam int unsigned PROD_W  = YY_W + 13;

  logic              jan_feb;
  logic [YY_W-1:0]   yy;
  logic [MONTH_W-1:0] mm;
  logic [PROD_W-1:0] prod;
  logic [8:0]        q100;
  logic [6:0]        q400;
  logic [12:0]       q4;
  logic [SUM_W-1:0]  total;
  logic [5:0]        fold1;
  logic [3:0]        fold2;
  logic [WD_W-1:0]   sun0;

  // January and February count as months 11 and 12 of the previous year.
  // Four hundred extra years keep the sum positive and span whole weeks.
  always_comb begin
    jan_feb = (month <= MONTH_FEB);
    yy      = YY_W'(year) + YY_W'(400) - YY_W'(jan_feb);
    mm      = jan_feb ? (month + MONTH_W'(10)) : (month - MONTH_W'(2));
  end

  // Century terms by reciprocal multiplication.
  always_comb begin
    prod = PROD_W'(yy) * PROD_W'(R100);
    q100 = prod[R100_SH +: 9];
    q400 = q100[8:2];
    q4   = yy[YY_W-1:2];
  end

  // Day-of-week congruence, Sunday based, before the reduction by seven.
  always_comb begin
    total = SUM_W'(day) + SUM_W'(yy) + SUM_W'(q4) + SUM_W'(q400)
          + SUM_W'(month_term(mm)) - SUM_W'(q100);
  end

  // Reduce modulo seven by folding octal digits, since eight is one modulo seven.
  always_comb begin
    fold1 = 6'(total[2:0]) + 6'(total[5:3]) + 6'(total[8:6])
          + 6'(total[11:9]) + 6'(total[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    sun0  = (fold2 >= 4'd7) ? WD_W'(fold2 - 4'd7) : WD_W'(fold2);
  end

  // Shift to Monday as day zero.
  assign weekday = (sun0 == '0) ? WD_SUN : (sun0 - WD_W'(1));

endmodule

/* rtl/gdi_calendar.sv */
// Date check, leap year, days left in month and year, and the following date.
module gdi_calendar
  import gdi_pkg::*;
(
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output cal_t               cal
);

  // Reciprocal of 25 scaled by 2^18; exact for every 14-bit year.
  localparam int unsigned R25_SH = 18;
  localparam logic [13:0] R25    = 14'd10486;
  localparam int unsigned PROD_W = YEAR_W + 14;

  logic [PROD_W-1:0] prod;
  logic [9:0]        q25;
  logic [YEAR_W:0]   back25;
  logic              div25;
  logic              leap;
  logic [DAY_W-1:0]  dim;
  logic [DOY_W-1:0]  doy;
  logic [DOY_W-1:0]  diy;
  logic              month_last;

  // Leap year: divisible by 4 and not by 100, or divisible by 400.
  // By 100 means by 4 and by 25; by 400 means by 16 and by 25.
  always_comb begin
    prod   = PROD_W'(year) * PROD_W'(R25);
    q25    = prod[R25_SH +: 10];
    back25 = {1'b0, q25, 4'b0} + {2'b0, q25, 3'b0} + (YEAR_W+1)'(q25);
    div25  = (back25 == {1'b0, year});
    leap   = ((year[1:0] == 2'b0) && !div25) || ((year[3:0] == 4'b0) && div25);
  end

  // Month length, day of year and year length.
  always_comb begin
    dim = days_in_month(month, leap);
    doy = days_before(month) + DOY_W'(day) + DOY_W'(leap && (month > MONTH_FEB));
    diy = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
  end

  // Date check, days remaining and the following date.
  always_comb begin
    // A real date has a year in range, a known month and a day within it.
    cal.date_ok = (year >= YEAR_MIN) && (year <= YEAR_MAX) && (dim != '0)
               && (day != '0) && (day <= dim);

    // Days remaining, counting today.
    cal.days_to_month_end = dim - day + DAY_W'(1);
    cal.days_to_year_end  = diy - doy + DOY_W'(1);

    // Following date, rolling over at month and year end.
    month_last = (day == dim);
    if (month_last) begin
      cal.next_day = DAY_FIRST;
      if (month == MONTH_DEC) begin
        cal.next_month = MONTH_JAN;
        cal.next_year  = year + YEAR_W'(1);
      end else begin
        cal.next_month = month + MONTH_W'(1);
        cal.next_year  = year;
      end
    end else begin
      cal.next_day   = day + DAY_W'(1);
      cal.next_month = month;
      cal.next_year  = year;
    end
  end

endmodule
